/* hw/rtl/gbi_pkg.sv */
// gbi_pkg: shared types and constants of the grid bilinear interpolation core.
// Used by the divider, the top level and the port checker. No dependencies.
package gbi_pkg;

  // Result status codes.
  localparam logic [2:0] ST_BILINEAR = 3'd0;
  localparam logic [2:0] ST_MEAN     = 3'd1;
  localparam logic [2:0] ST_NEIGHBOR = 3'd2;
  localparam logic [2:0] ST_EDGE     = 3'd3;
  localparam logic [2:0] ST_NODATA   = 3'd4;
  localparam logic [2:0] ST_REJECT   = 3'd5;

  // Item kinds.
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Configuration register indexes.
  localparam logic [2:0] REG_X_ORIGIN = 3'd0;
  localparam logic [2:0] REG_Y_ORIGIN = 3'd1;
  localparam logic [2:0] REG_CELL     = 3'd2;
  localparam logic [2:0] REG_NODATA   = 3'd3;
  localparam logic [2:0] REG_COLS     = 3'd4;
  localparam logic [2:0] REG_ROWS     = 3'd5;

  // Shared divider widths.
  localparam int DIV_NW = 34;
  localparam int DIV_DW = 16;

  typedef struct packed {
    logic              go;
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quot;
    logic [DIV_DW-1:0] rem;
  } div_rsp_t;

  // Fallback neighbor order: row and column selectors.
  typedef enum logic [1:0] {ROW_N, ROW_S0, ROW_S1} nb_row_t;
  typedef enum logic [1:0] {COL_W, COL_C, COL_E} nb_col_t;

  localparam nb_row_t NB_ROW [8] = '{ROW_N, ROW_S1, ROW_S0, ROW_S0,
                                     ROW_N, ROW_N, ROW_S1, ROW_S1};
  localparam nb_col_t NB_COL [8] = '{COL_C, COL_C, COL_W, COL_E,
                                     COL_W, COL_E, COL_W, COL_E};

endpackage

/* hw/rtl/grid_bilinear_nodata_interp_core.sv */
// grid_bilinear_nodata_interp_core: raster grid store with bilinear / nodata-aware lookup.
// Depends on gbi_pkg, gbi_div and gbi_grid_mem.
//
//   channel   direction  signals                                   transfer when
//   command   in         start, busy, kind, row, col, cell_value,  start && !busy
//                        x_pos, y_pos
//   result    out        done, result_value, status                done (one cycle)
//   config    in         cfg_we, cfg_index, cfg_data               cfg_we
//
// A write or a point rejected at once raises done in the cycle after the transfer, and busy
// stays low, so writes can stream one per cycle. A query uses the shared radix-2 divider
// and the one memory port; busy is low again with done.
// rst is synchronous, clears the control state and loads the register defaults; the grid
// store is not cleared. The receiver cannot stall: each result shows for one cycle only.
module grid_bilinear_nodata_interp_core #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 512
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               kind,
  input  logic [8:0]         row,
  input  logic [9:0]         col,
  input  logic signed [31:0] cell_value,
  input  logic signed [31:0] x_pos,
  input  logic signed [31:0] y_pos,
  output logic               done,
  output logic signed [31:0] result_value,
  output logic [2:0]         status,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import gbi_pkg::*;

  localparam int CW = $clog2(MAX_COLS);
  localparam int RW = $clog2(MAX_ROWS);
  localparam int AW = CW + RW;

  typedef enum logic [4:0] {
    S_IDLE, S_DIV_I, S_DIV_J, S_CHECK, S_RD_EDGE, S_EDGE_W, S_RD_CORNER, S_CORNER_W,
    S_EVAL, S_DIV_WX, S_DIV_WY, S_MUL_N, S_MUL_S, S_DIFF, S_MUL_LO, S_MUL_HI, S_ROUND,
    S_DIV_MEAN, S_NB, S_NB_W
  } state_t;

  // Configuration registers.
  logic signed [31:0] x_origin, y_origin, nodata_mark;
  logic [15:0]        cell_size;
  logic [10:0]        cols_in_use;
  logic [9:0]         rows_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_origin    <= 32'sd425472000;
      y_origin    <= 32'sd151040000;
      cell_size   <= 16'd1000;
      nodata_mark <= -32'sd2559744;
      cols_in_use <= 11'd605;
      rows_in_use <= 10'd271;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_X_ORIGIN: x_origin    <= cfg_data;
        REG_Y_ORIGIN: y_origin    <= cfg_data;
        REG_CELL:     cell_size   <= cfg_data[15:0];
        REG_NODATA:   nodata_mark <= cfg_data;
        REG_COLS:     cols_in_use <= cfg_data[10:0];
        REG_ROWS:     rows_in_use <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // Grid size in use, saturated to the store's dimensions.
  logic [12:0] nx, ny, nx_m1, ny_m1;
  assign nx = ({2'b0, cols_in_use} > 13'(MAX_COLS)) ? 13'(MAX_COLS) : {2'b0, cols_in_use};
  assign ny = ({3'b0, rows_in_use} > 13'(MAX_ROWS)) ? 13'(MAX_ROWS) : {3'b0, rows_in_use};
  assign nx_m1 = nx - 13'd1;
  assign ny_m1 = ny - 13'd1;

  // Offsets of the query point from the origin, exact in 33 bits.
  logic signed [32:0] ox_c, oy_c;
  assign ox_c = 33'(x_pos) - 33'(x_origin);
  assign oy_c = 33'(y_pos) - 33'(y_origin);

  // Working registers.
  state_t             state;
  logic [31:0]        ox, oy;
  logic [23:0]        ci, cj;
  logic [15:0]        rem_x, rem_y, wx, wy;
  logic [2:0]         k;
  logic signed [31:0] a_r [4];
  logic               neg;
  logic signed [50:0] north, south;
  logic signed [51:0] d;
  logic signed [67:0] acc;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  // Memory port.
  logic        mem_we;
  logic [AW-1:0] mem_addr;
  logic [31:0] mem_rdata;

  // Cell-index helpers.
  logic [12:0] ii, jj, rn, rs0, rs1, ic, jc, er;
  logic [12:0] c_row, c_col, n_row, n_col;
  logic        n_ok;
  logic [12:0] row13, col13;
  logic        wr_ok;

  assign ii  = ci[12:0];
  assign jj  = cj[12:0];
  assign rn  = ny - 13'd2 - jj;
  assign rs0 = ny_m1 - jj;
  assign rs1 = ny - jj;
  assign ic  = (ci > 24'(nx_m1)) ? nx_m1 : ii;
  assign jc  = (cj > 24'(ny_m1)) ? ny_m1 : jj;
  assign er  = ny_m1 - jc;
  assign c_row = k[0] ? rs0 : rn;
  assign c_col = ii + 13'(k[1]);
  assign row13 = 13'(row);
  assign col13 = 13'(col);
  assign wr_ok = (row13 < 13'(MAX_ROWS)) && (col13 < 13'(MAX_COLS));

  // Fallback neighbor: position and whether it lies on the grid.
  always_comb begin
    n_ok = 1'b1;
    unique case (NB_ROW[k])
      ROW_N:   n_row = rn;
      ROW_S0:  n_row = rs0;
      ROW_S1: begin
        n_row = rs1;
        n_ok  = (jj != 13'd0);
      end
      default: n_row = rn;
    endcase
    unique case (NB_COL[k])
      COL_W: begin
        n_col = ii - 13'd1;
        n_ok  = n_ok && (ii != 13'd0);
      end
      COL_C:   n_col = ii;
      COL_E:   n_col = ii + 13'd1;
      default: n_col = ii;
    endcase
  end

  // The memory address follows the state: a write on acceptance of an in-range write, otherwise a read.
  always_comb begin
    mem_we   = 1'b0;
    mem_addr = {er[RW-1:0], ic[CW-1:0]};
    unique case (state)
      S_IDLE: begin
        mem_we   = start && (kind == KIND_WRITE) && wr_ok;
        mem_addr = {row13[RW-1:0], col13[CW-1:0]};
      end
      S_RD_CORNER: mem_addr = {c_row[RW-1:0], c_col[CW-1:0]};
      S_NB:        mem_addr = {n_row[RW-1:0], n_col[CW-1:0]};
      default:     mem_addr = {er[RW-1:0], ic[CW-1:0]};
    endcase
  end

  // Corner evaluation: count and sum of the corners that hold data.
  logic signed [33:0] sum_c;
  logic [2:0]         cnt_c;
  logic [33:0]        sum_mag;
  always_comb begin
    sum_c = '0;
    cnt_c = '0;
    for (int n = 0; n < 4; n++) begin
      if (a_r[n] != nodata_mark) begin
        sum_c = sum_c + 34'(a_r[n]);
        cnt_c = cnt_c + 3'd1;
      end
    end
  end
  assign sum_mag = sum_c[33] ? 34'(-sum_c) : sum_c;

  // The one multiplier, about 34 by 18 bits; its product is always registered.
  logic signed [32:0] diff_c;
  logic signed [33:0] mul_x;
  logic signed [17:0] mul_y;
  logic signed [51:0] mul_p;
  always_comb begin
    diff_c = '0;
    mul_x  = '0;
    mul_y  = $signed({2'b0, wx});
    unique case (state)
      S_MUL_N: begin
        diff_c = 33'(a_r[2]) - 33'(a_r[0]);
        mul_x  = 34'(diff_c);
      end
      S_MUL_S: begin
        diff_c = 33'(a_r[3]) - 33'(a_r[1]);
        mul_x  = 34'(diff_c);
      end
      S_MUL_LO: begin
        mul_x = $signed({8'b0, d[25:0]});
        mul_y = $signed({2'b0, wy});
      end
      S_MUL_HI: begin
        mul_x = 34'($signed(d[51:26]));
        mul_y = $signed({2'b0, wy});
      end
      default: ;
    endcase
  end
  assign mul_p = mul_x * mul_y;

  // Rounded bilinear result and signed mean.
  logic signed [67:0] rnd;
  logic [33:0]        mean_v;
  assign rnd    = acc + (68'sd1 <<< 31);
  assign mean_v = neg ? (34'd0 - div_rsp.quot) : div_rsp.quot;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      done       <= 1'b0;
      div_req.go <= 1'b0;
    end else begin
      done       <= 1'b0;
      div_req.go <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            if (kind == KIND_WRITE) begin
              done         <= 1'b1;
              result_value <= '0;
              status       <= ST_REJECT;
            end else if (nx < 13'd2 || ny < 13'd2 || cell_size == 16'd0 ||
                         ox_c[32] || oy_c[32]) begin
              done         <= 1'b1;
              result_value <= '0;
              status       <= ST_REJECT;
            end else begin
              ox          <= ox_c[31:0];
              oy          <= oy_c[31:0];
              div_req.num <= 34'(ox_c[31:8]);
              div_req.den <= cell_size;
              div_req.go  <= 1'b1;
              state       <= S_DIV_I;
            end
          end
        end
        S_DIV_I: begin
          if (div_rsp.done) begin
            ci          <= div_rsp.quot[23:0];
            rem_x       <= div_rsp.rem;
            div_req.num <= 34'(oy[31:8]);
            div_req.go  <= 1'b1;
            state       <= S_DIV_J;
          end
        end
        S_DIV_J: begin
          if (div_rsp.done) begin
            cj    <= div_rsp.quot[23:0];
            rem_y <= div_rsp.rem;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (ci > 24'(nx) || cj > 24'(ny)) begin
            done         <= 1'b1;
            result_value <= '0;
            status       <= ST_REJECT;
            state        <= S_IDLE;
          end else if (ci >= 24'(nx_m1) || cj >= 24'(ny_m1)) begin
            state <= S_RD_EDGE;
          end else begin
            k     <= '0;
            state <= S_RD_CORNER;
          end
        end
        S_RD_EDGE: state <= S_EDGE_W;
        S_EDGE_W: begin
          done         <= 1'b1;
          result_value <= mem_rdata;
          status       <= ST_EDGE;
          state        <= S_IDLE;
        end
        S_RD_CORNER: state <= S_CORNER_W;
        S_CORNER_W: begin
          a_r[k[1:0]] <= mem_rdata;
          k           <= k + 3'd1;
          state       <= (k == 3'd3) ? S_EVAL : S_RD_CORNER;
        end
        S_EVAL: begin
          if (cnt_c == 3'd4) begin
            div_req.num <= 34'({rem_x, ox[7:0], 8'b0});
            div_req.go  <= 1'b1;
            state       <= S_DIV_WX;
          end else if (cnt_c != 3'd0) begin
            neg         <= sum_c[33];
            div_req.num <= sum_mag;
            div_req.den <= 16'(cnt_c);
            div_req.go  <= 1'b1;
            state       <= S_DIV_MEAN;
          end else begin
            k     <= '0;
            state <= S_NB;
          end
        end
        S_DIV_WX: begin
          if (div_rsp.done) begin
            wx          <= div_rsp.quot[15:0];
            div_req.num <= 34'({rem_y, oy[7:0], 8'b0});
            div_req.go  <= 1'b1;
            state       <= S_DIV_WY;
          end
        end
        S_DIV_WY: begin
          if (div_rsp.done) begin
            wy    <= div_rsp.quot[15:0];
            state <= S_MUL_N;
          end
        end
        S_MUL_N: begin
          north <= (51'(a_r[0]) <<< 16) + 51'(mul_p);
          state <= S_MUL_S;
        end
        S_MUL_S: begin
          south <= (51'(a_r[1]) <<< 16) + 51'(mul_p);
          state <= S_DIFF;
        end
        S_DIFF: begin
          d     <= 52'(north) - 52'(south);
          state <= S_MUL_LO;
        end
        S_MUL_LO: begin
          acc   <= (68'(south) <<< 16) + 68'(mul_p);
          state <= S_MUL_HI;
        end
        S_MUL_HI: begin
          acc   <= acc + (68'(mul_p) <<< 26);
          state <= S_ROUND;
        end
        S_ROUND: begin
          done         <= 1'b1;
          result_value <= rnd[63:32];
          status       <= ST_BILINEAR;
          state        <= S_IDLE;
        end
        S_DIV_MEAN: begin
          if (div_rsp.done) begin
            done         <= 1'b1;
            result_value <= mean_v[31:0];
            status       <= ST_MEAN;
            state        <= S_IDLE;
          end
        end
        S_NB: begin
          if (n_ok) begin
            state <= S_NB_W;
          end else if (k == 3'd7) begin
            done         <= 1'b1;
            result_value <= '0;
            status       <= ST_NODATA;
            state        <= S_IDLE;
          end else begin
            k <= k + 3'd1;
          end
        end
        S_NB_W: begin
          if (mem_rdata != nodata_mark) begin
            done         <= 1'b1;
            result_value <= mem_rdata;
            status       <= ST_NEIGHBOR;
            state        <= S_IDLE;
          end else if (k == 3'd7) begin
            done         <= 1'b1;
            result_value <= '0;
            status       <= ST_NODATA;
            state        <= S_IDLE;
          end else begin
            k     <= k + 3'd1;
            state <= S_NB;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy = (state != S_IDLE);

  gbi_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  gbi_grid_mem #(.AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (cell_value),
    .rdata (mem_rdata)
  );

endmodule

/* hw/rtl/gbi_div.sv */
// gbi_div: radix-2 restoring divider, one quotient bit per cycle.
// Depends on gbi_pkg for the request and response structs.
module gbi_div (
  input  logic             clk,
  input  logic             rst,
  input  gbi_pkg::div_req_t req,
  output gbi_pkg::div_rsp_t rsp
);
  import gbi_pkg::*;

  logic [DIV_NW-1:0] q;
  logic [DIV_DW-1:0] r;
  logic [DIV_DW-1:0] d;
  logic [5:0]        cnt;
  logic              run;
  logic              done;
  logic [DIV_DW:0]   shifted;
  logic [DIV_DW:0]   trial;

  assign shifted = {r, q[DIV_NW-1]};
  assign trial   = shifted - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        q    <= req.num;
        d    <= req.den;
        r    <= '0;
        cnt  <= 6'(DIV_NW);
        run  <= 1'b1;
      end else if (run) begin
        if (!trial[DIV_DW]) begin
          r <= trial[DIV_DW-1:0];
          q <= {q[DIV_NW-2:0], 1'b1};
        end else begin
          r <= shifted[DIV_DW-1:0];
          q <= {q[DIV_NW-2:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = q;
  assign rsp.rem  = r;

endmodule

/* hw/rtl/gbi_grid_mem.sv */
// gbi_grid_mem: single-port synchronous grid store, read-first, with a registered read.
// No dependencies.
module gbi_grid_mem #(
  parameter int AW = 19
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [31:0]   wdata,
  output logic [31:0]   rdata
);
  logic [31:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* hw/rtl/gbi_checker.sv */
// gbi_checker: port-level assertions for the grid interpolation core, bound to the top.
// Depends on gbi_pkg for the status codes.
module gbi_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               kind,
  input logic               done,
  input logic signed [31:0] result_value,
  input logic [2:0]         status
);
  import gbi_pkg::*;

  // A result is shown only once the block has returned to idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result shown while busy");

  // A write is acknowledged on the next cycle with the reject code.
  a_write_ack: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && kind == KIND_WRITE) |=> (done && status == ST_REJECT))
    else $error("write not acknowledged");

  // No-data and reject results carry zero.
  a_zero_val: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_NODATA || status == ST_REJECT)) |-> (result_value == 32'sd0))
    else $error("nonzero value with no-data or reject status");

  // Every result follows a transfer or the end of a busy period.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) || $past(start)))
    else $error("result without a transfer");

  // The block turns busy only on a query transfer.
  a_busy_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> ($past(start) && $past(kind) == KIND_QUERY))
    else $error("busy without a query");

endmodule

bind grid_bilinear_nodata_interp_core gbi_checker u_gbi_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .kind         (kind),
  .done         (done),
  .result_value (result_value),
  .status       (status)
);
